### hdl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// shared constants and types of the thruster frame checker
// ----------------------------------------------------------------------------
package tfc_pkg;

    // number of pulse-width channels in a frame
    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // frame layout
    localparam logic [7:0] HDR_BYTES   = 8'd6;
    localparam logic [7:0] FRAME_BYTES = 8'(6 + 2 * CHANNELS + 2);
    localparam logic [7:0] DATA_END    = FRAME_BYTES - 8'd2;
    localparam logic [7:0] POS_VERSION = 8'd4;
    localparam logic [7:0] POS_SEQ     = 8'd5;
    localparam logic [7:0] POS_MAGIC   = 8'd4;
    localparam logic [7:0] POS_CRC_GO  = 8'd2;
    localparam logic [7:0] POS_MAX     = 8'd255;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // result status codes
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] STATUS_BAD_CRC     = 3'd3;
    localparam logic [2:0] STATUS_BAD_VERSION = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MAGIC_0  = 3'd0;
    localparam logic [2:0] REG_MAGIC_1  = 3'd1;
    localparam logic [2:0] REG_MAGIC_2  = 3'd2;
    localparam logic [2:0] REG_MAGIC_3  = 3'd3;
    localparam logic [2:0] REG_VERSION  = 3'd4;

    // control of the bit-serial crc unit
    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } crc_ctl_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } crc_sts_t;

    // byte write into the channel store
    typedef struct packed {
        logic                en_lo;
        logic                en_hi;
        logic [CH_IDX_W-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

endpackage

### hdl/thruster_frame_checker.sv
// ----------------------------------------------------------------------------
// thruster_frame_checker
// checks framed thruster commands and hands out per-channel pulse widths
// ----------------------------------------------------------------------------
// usage
//   s_ side: one frame byte per transaction in s_tdata, s_tlast on the final
//   byte. m_ side: one transaction per result; a frame failing the length, magic
//   or crc checks gives a single status transaction, any other gives one transaction per channel.
//   the apb port holds the four magic bytes and the accepted version.
// timing
//   the first two bytes of a frame are taken without leaving idle; every
//   later byte is accepted, shifted through the bit-serial crc unit and
//   seen idle by the sequencer before the next byte is taken. a bad-frame
//   status is loaded from evaluation once the final byte has passed the crc
//   unit (straight after it for a frame of one or two bytes); on a good frame
//   evaluation is followed by a store read and an output load per channel.
// reset
//   aresetn clears the crc, the registers and the frame state bar the crc
//   candidate; the channel store is not cleared, every entry is rewritten by a full-length frame.
// stall
//   results sit in an output register; a stalled receiver holds the
//   sequencer before the next load, and a new frame may start while the
//   final result still waits.
// ----------------------------------------------------------------------------
module thruster_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // frame_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] frame_version, [15:8] frame_sequence,
                                   // [19:16] channel_index, [35:20] pulse_width,
                                   // [39:36] zero
    output logic [3:0]  m_tuser,   // [2:0] status, [3] pulse_present
    output logic        m_tlast,   // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CRC  = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_RD   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [7:0] magic0_reg, magic1_reg, magic2_reg, magic3_reg, version_cfg_reg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    // frame state
    logic [7:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  dly0_reg, dly0_next;
    logic [7:0]  dly1_reg, dly1_next;
    logic        magic_bad_reg, magic_bad_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic        last_reg, last_next;
    logic        len_ok_reg, len_ok_next;
    logic [15:0] got_crc_reg, got_crc_next;
    logic [tfc_pkg::CH_IDX_W-1:0] emit_reg, emit_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;
    logic [3:0]  m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    // datapath helpers
    tfc_pkg::crc_ctl_t  crc_ctl;
    tfc_pkg::crc_sts_t  crc_sts;
    tfc_pkg::store_wr_t store_wr;
    logic               rd_en;
    logic [15:0]        rd_data;
    logic               s_accept;
    logic               out_free;
    logic [7:0]         pos;
    logic [7:0]         data_off;
    logic [7:0]         magic_want;
    logic [2:0]         err_status;
    logic [2:0]         ok_status;
    logic               emit_last;

    // bit-serial crc over the byte leaving the delay line
    tfc_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .sts     (crc_sts)
    );

    // pulse-width store
    tfc_chan_store u_store (
        .aclk    (aclk),
        .wr      (store_wr),
        .rd_en   (rd_en),
        .rd_addr (emit_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // apb register file, always ready, one write per access phase
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic0_reg      <= 8'h00;
            magic1_reg      <= 8'h00;
            magic2_reg      <= 8'h00;
            magic3_reg      <= 8'h00;
            version_cfg_reg <= 8'h00;
        end else if (cfg_wr) begin
            case (reg_idx)
                tfc_pkg::REG_MAGIC_0: magic0_reg      <= pwdata[7:0];
                tfc_pkg::REG_MAGIC_1: magic1_reg      <= pwdata[7:0];
                tfc_pkg::REG_MAGIC_2: magic2_reg      <= pwdata[7:0];
                tfc_pkg::REG_MAGIC_3: magic3_reg      <= pwdata[7:0];
                tfc_pkg::REG_VERSION: version_cfg_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tfc_pkg::REG_MAGIC_0: prdata = 32'(magic0_reg);
            tfc_pkg::REG_MAGIC_1: prdata = 32'(magic1_reg);
            tfc_pkg::REG_MAGIC_2: prdata = 32'(magic2_reg);
            tfc_pkg::REG_MAGIC_3: prdata = 32'(magic3_reg);
            tfc_pkg::REG_VERSION: prdata = 32'(version_cfg_reg);
            default:              prdata = 32'h0000_0000;
        endcase
    end

    // ------------------------------------------------------------------
    // decode helpers
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign pos      = byte_cnt_reg;
    assign data_off = pos - tfc_pkg::HDR_BYTES;
    assign emit_last = (emit_reg == tfc_pkg::CH_IDX_W'(tfc_pkg::CHANNELS - 1));

    always_comb begin
        case (pos[1:0])
            2'd0:    magic_want = magic0_reg;
            2'd1:    magic_want = magic1_reg;
            2'd2:    magic_want = magic2_reg;
            default: magic_want = magic3_reg;
        endcase
    end

    // checks in priority order: length, magic, crc
    always_comb begin
        if (!len_ok_reg) begin
            err_status = tfc_pkg::STATUS_BAD_LENGTH;
        end else if (magic_bad_reg) begin
            err_status = tfc_pkg::STATUS_BAD_MAGIC;
        end else if (crc_sts.crc != got_crc_reg) begin
            err_status = tfc_pkg::STATUS_BAD_CRC;
        end else begin
            err_status = tfc_pkg::STATUS_OK;
        end
    end

    assign ok_status = (version_reg == version_cfg_reg) ? tfc_pkg::STATUS_OK
                                                        : tfc_pkg::STATUS_BAD_VERSION;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        byte_cnt_next  = byte_cnt_reg;
        dly0_next      = dly0_reg;
        dly1_next      = dly1_reg;
        magic_bad_next = magic_bad_reg;
        version_next   = version_reg;
        sequence_next  = sequence_reg;
        last_next      = last_reg;
        len_ok_next    = len_ok_reg;
        got_crc_next   = got_crc_reg;
        emit_next      = emit_reg;
        m_valid_next   = m_valid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        crc_ctl        = '0;
        store_wr       = '0;
        rd_en          = 1'b0;

        // receiver took the pending result
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // capture fields by position
                    if (pos < tfc_pkg::POS_MAGIC) begin
                        if (s_tdata != magic_want) begin
                            magic_bad_next = 1'b1;
                        end
                    end else if (pos == tfc_pkg::POS_VERSION) begin
                        version_next = s_tdata;
                    end else if (pos == tfc_pkg::POS_SEQ) begin
                        sequence_next = s_tdata;
                    end else if (pos < tfc_pkg::DATA_END) begin
                        store_wr.en_lo = !data_off[0];
                        store_wr.en_hi = data_off[0];
                        store_wr.addr  = data_off[tfc_pkg::CH_IDX_W:1];
                        store_wr.data  = s_tdata;
                    end
                    // trailing crc candidate, previous byte low
                    got_crc_next = {s_tdata, dly0_reg};
                    len_ok_next  = (pos == tfc_pkg::FRAME_BYTES - 8'd1);
                    last_next    = s_tlast;
                    dly1_next    = dly0_reg;
                    dly0_next    = s_tdata;
                    if (pos != tfc_pkg::POS_MAX) begin
                        byte_cnt_next = pos + 8'd1;
                    end
                    if (pos >= tfc_pkg::POS_CRC_GO) begin
                        crc_ctl.start = 1'b1;
                        crc_ctl.data  = dly1_reg;
                        state_next    = ST_CRC;
                    end else if (s_tlast) begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_CRC: begin
                if (!crc_sts.busy) begin
                    state_next = last_reg ? ST_EVAL : ST_IDLE;
                end
            end
            ST_EVAL: begin
                if (err_status != tfc_pkg::STATUS_OK) begin
                    if (out_free) begin
                        m_valid_next   = 1'b1;
                        m_tdata_next   = 40'h00_0000_0000;
                        m_tuser_next   = {1'b0, err_status};
                        m_tlast_next   = 1'b1;
                        // frame done, back to reset values
                        byte_cnt_next  = 8'h00;
                        dly0_next      = 8'h00;
                        dly1_next      = 8'h00;
                        magic_bad_next = 1'b0;
                        version_next   = 8'h00;
                        sequence_next  = 8'h00;
                        last_next      = 1'b0;
                        emit_next      = '0;
                        crc_ctl.clear  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    emit_next  = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_tdata_next = {4'h0, rd_data, 4'(emit_reg), sequence_reg, version_reg};
                    m_tuser_next = {1'b1, ok_status};
                    m_tlast_next = emit_last;
                    if (emit_last) begin
                        byte_cnt_next  = 8'h00;
                        dly0_next      = 8'h00;
                        dly1_next      = 8'h00;
                        magic_bad_next = 1'b0;
                        version_next   = 8'h00;
                        sequence_next  = 8'h00;
                        last_next      = 1'b0;
                        emit_next      = '0;
                        crc_ctl.clear  = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        emit_next  = emit_reg + tfc_pkg::CH_IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            byte_cnt_reg  <= 8'h00;
            dly0_reg      <= 8'h00;
            dly1_reg      <= 8'h00;
            magic_bad_reg <= 1'b0;
            version_reg   <= 8'h00;
            sequence_reg  <= 8'h00;
            last_reg      <= 1'b0;
            len_ok_reg    <= 1'b0;
            emit_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            dly0_reg      <= dly0_next;
            dly1_reg      <= dly1_next;
            magic_bad_reg <= magic_bad_next;
            version_reg   <= version_next;
            sequence_reg  <= sequence_next;
            last_reg      <= last_next;
            len_ok_reg    <= len_ok_next;
            emit_reg      <= emit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        got_crc_reg <= got_crc_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // no byte is taken while the crc unit still shifts
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        crc_sts.busy |-> !s_tready)
        else $error("input accepted while crc unit busy");

    // the final byte always leads into crc or evaluation
    a_last_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> !s_tready)
        else $error("ready right after final byte");

    // the final channel load marks the result as last
    a_last_channel_tlast: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free && emit_last) |=> (m_tvalid && m_tlast))
        else $error("last channel result without tlast");

    // early rejections never carry a pulse width
    a_reject_no_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] != tfc_pkg::STATUS_OK
                  && m_tuser[2:0] != tfc_pkg::STATUS_BAD_VERSION)
        |-> (!m_tuser[3] && m_tlast))
        else $error("rejection status with pulse data");

endmodule

### hdl/tfc_crc_unit.sv
// ----------------------------------------------------------------------------
// tfc_crc_unit
// bit-serial crc-16 engine, one message bit per cycle
// ----------------------------------------------------------------------------
module tfc_crc_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  tfc_pkg::crc_ctl_t ctl,
    output tfc_pkg::crc_sts_t sts
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        feedback;

    always_comb begin
        crc_next   = crc_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        busy_next  = busy_reg;
        feedback   = crc_reg[15] ^ shift_reg[7];
        if (ctl.clear) begin
            crc_next  = tfc_pkg::CRC_INIT;
            busy_next = 1'b0;
        end else if (ctl.start) begin
            shift_next = ctl.data;
            bit_next   = 3'd0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            crc_next   = {crc_reg[14:0], 1'b0} ^ (feedback ? tfc_pkg::CRC_POLY : 16'h0000);
            shift_next = {shift_reg[6:0], 1'b0};
            bit_next   = bit_reg + 3'd1;
            if (bit_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= tfc_pkg::CRC_INIT;
            shift_reg <= 8'h00;
            bit_reg   <= 3'd0;
            busy_reg  <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            busy_reg  <= busy_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.crc  = crc_reg;

endmodule

### hdl/tfc_chan_store.sv
// ----------------------------------------------------------------------------
// tfc_chan_store
// pulse-width store, byte-lane writes and registered read
// ----------------------------------------------------------------------------
module tfc_chan_store (
    input  logic                         aclk,
    input  tfc_pkg::store_wr_t           wr,
    input  logic                         rd_en,
    input  logic [tfc_pkg::CH_IDX_W-1:0] rd_addr,
    output logic [15:0]                  rd_data
);

    logic [7:0] mem_lo [tfc_pkg::CHANNELS];
    logic [7:0] mem_hi [tfc_pkg::CHANNELS];

    always_ff @(posedge aclk) begin
        if (wr.en_lo) begin
            mem_lo[wr.addr] <= wr.data;
        end
        if (wr.en_hi) begin
            mem_hi[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= {mem_hi[rd_addr], mem_lo[rd_addr]};
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the thruster frame checker: a queue-fed byte
// driver, a result monitor and a byte-by-byte frame predictor; frames are
// mostly well formed with random content, mixed with corrupted, short,
// long and noise frames, under several register settings and idle patterns
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAME_LEN   = int'(tfc_pkg::FRAME_BYTES);
    localparam int SETTLE      = 30;       // covers the per-byte crc wait and the status delay
    localparam int CYCLE_LIMIT = 600000;   // many times the slowest expected run
    localparam int HOLD_CYCLES = 700;      // long receiver hold-off for the pressure phase
    localparam logic [2:0] REG_UNUSED = 3'd5;  // address with no register behind it

    // kinds of generated frames
    typedef enum int {
        FR_GOOD, FR_BAD_VERSION, FR_BAD_MAGIC, FR_BAD_CRC,
        FR_SHORT, FR_LONG, FR_HUGE, FR_NOISE
    } frame_kind_t;

    // one input transaction
    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    // one result transaction, field by field
    typedef struct {
        logic [2:0]  status;
        logic [7:0]  version;
        logic [7:0]  seq_num;
        logic [3:0]  channel;
        logic [15:0] pulse;
        logic        present;
        logic        last;
    } frame_result_t;

    // dut ports; the inputs are all driven to known values from time zero
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus side
    frame_byte_t   byte_queue[$];         // bytes waiting for the driver
    frame_result_t expected_results[$];   // predicted results, oldest first
    logic [7:0]    gen_magic[4];          // register values the generator builds frames for
    logic [7:0]    gen_version;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_req = 1'b0;       // toggled to ask the receiver for a hold-off
    bit            hold_ack = 1'b0;
    int            hold_left = 0;
    bit            in_taken = 1'b0;       // input transaction at the last rising edge

    // predictor state: register shadow and frame state
    logic [7:0]  cfg_magic[4];
    logic [7:0]  cfg_version;
    logic [7:0]  fm_count;
    logic [15:0] fm_crc;
    logic [7:0]  fm_delay[2];
    logic        fm_magic_bad;
    logic [7:0]  fm_version;
    logic [7:0]  fm_seq;
    logic [15:0] pulse_store[tfc_pkg::CHANNELS];

    // bookkeeping
    int errors      = 0;
    int cycle_count = 0;
    int n_bytes     = 0;
    int n_frames    = 0;
    int n_results   = 0;
    int n_settings  = 0;

    thruster_frame_checker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock, 10 ns period
    initial begin
        forever #5 aclk = ~aclk;
    end

    // crc-16/ccitt-false, one byte msb first
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    // frame state back to its idle value, the pulse store is kept
    function automatic void frame_clear();
        fm_count     = 8'd0;
        fm_crc       = 16'hFFFF;
        fm_delay[0]  = 8'd0;
        fm_delay[1]  = 8'd0;
        fm_magic_bad = 1'b0;
        fm_version   = 8'd0;
        fm_seq       = 8'd0;
    endfunction

    // advance the frame predictor by one accepted byte, queue any results
    function automatic void frame_model_step(logic [7:0] b, logic fin);
        int            pos;
        int            off;
        logic [15:0]   got_crc;
        logic [2:0]    st;
        frame_result_t r;
        pos = int'(fm_count);
        // capture by byte position
        if (pos < 4) begin
            if (b != cfg_magic[pos]) fm_magic_bad = 1'b1;
        end else if (pos == int'(tfc_pkg::POS_VERSION)) begin
            fm_version = b;
        end else if (pos == int'(tfc_pkg::POS_SEQ)) begin
            fm_seq = b;
        end else if (pos < int'(tfc_pkg::HDR_BYTES) + 2 * tfc_pkg::CHANNELS) begin
            off = pos - int'(tfc_pkg::HDR_BYTES);
            if (off % 2 == 0) pulse_store[off / 2][7:0] = b;
            else              pulse_store[off / 2][15:8] = b;
        end
        // the last two bytes seen are the crc candidate, older bytes feed the crc
        got_crc = {b, fm_delay[0]};
        if (pos >= 2) fm_crc = crc_byte(fm_crc, fm_delay[1]);
        fm_delay[1] = fm_delay[0];
        fm_delay[0] = b;
        if (fm_count != 8'hFF) fm_count = fm_count + 8'd1;
        if (!fin) return;

        if (pos + 1 != FRAME_LEN || pos == 255) st = tfc_pkg::STATUS_BAD_LENGTH;
        else if (fm_magic_bad)                  st = tfc_pkg::STATUS_BAD_MAGIC;
        else if (fm_crc != got_crc)             st = tfc_pkg::STATUS_BAD_CRC;
        else                                    st = tfc_pkg::STATUS_OK;

        if (st != tfc_pkg::STATUS_OK) begin
            r = '{st, 8'd0, 8'd0, 4'd0, 16'd0, 1'b0, 1'b1};
            expected_results.push_back(r);
        end else begin
            st = (fm_version == cfg_version) ? tfc_pkg::STATUS_OK
                                             : tfc_pkg::STATUS_BAD_VERSION;
            for (int ch = 0; ch < tfc_pkg::CHANNELS; ch++) begin
                r = '{st, fm_version, fm_seq, 4'(ch), pulse_store[ch], 1'b1,
                      (ch == tfc_pkg::CHANNELS - 1)};
                expected_results.push_back(r);
            end
        end
        frame_clear();
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    // register write, setup then access cycle
    task automatic apb_write(logic [2:0] idx, logic [7:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(logic [7:0] m0, logic [7:0] m1, logic [7:0] m2,
                               logic [7:0] m3, logic [7:0] ver);
        gen_magic[0] = m0;
        gen_magic[1] = m1;
        gen_magic[2] = m2;
        gen_magic[3] = m3;
        gen_version  = ver;
        apb_write(tfc_pkg::REG_MAGIC_0, m0);
        apb_write(tfc_pkg::REG_MAGIC_1, m1);
        apb_write(tfc_pkg::REG_MAGIC_2, m2);
        apb_write(tfc_pkg::REG_MAGIC_3, m3);
        apb_write(tfc_pkg::REG_VERSION, ver);
        n_settings++;
    endtask

    // build one frame for the current register values and queue its bytes
    task automatic add_frame(frame_kind_t kind, bit extreme, inout int added);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        logic [15:0] pw;
        int          pos;
        int          n;
        int          r;
        for (int i = 0; i < 4; i++) fb.push_back(gen_magic[i]);
        fb.push_back(kind == FR_BAD_VERSION ? gen_version ^ 8'($urandom_range(1, 255))
                                            : gen_version);
        fb.push_back(extreme ? 8'hFF : 8'($urandom));
        for (int ch = 0; ch < tfc_pkg::CHANNELS; ch++) begin
            r = $urandom_range(0, 99);
            if (extreme)     pw = (ch % 2 == 0) ? 16'h0000 : 16'hFFFF;
            else if (r < 8)  pw = 16'h0000;
            else if (r < 16) pw = 16'hFFFF;
            else             pw = 16'($urandom);
            fb.push_back(pw[7:0]);
            fb.push_back(pw[15:8]);
        end
        crc = 16'hFFFF;
        for (int i = 0; i < FRAME_LEN - 2; i++) crc = crc_byte(crc, fb[i]);
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);

        case (kind)
            FR_BAD_MAGIC: begin
                pos = $urandom_range(0, 3);
                fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
            end
            FR_BAD_CRC: begin
                // one flipped bit anywhere past the magic
                pos = $urandom_range(4, FRAME_LEN - 1);
                fb[pos] = fb[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
            FR_SHORT: begin
                n = $urandom_range(1, FRAME_LEN - 1);
                while (fb.size() > n) void'(fb.pop_back());
            end
            FR_LONG: begin
                n = $urandom_range(1, 16);
                repeat (n) fb.push_back(8'($urandom));
            end
            FR_HUGE: begin
                // runs the byte counter into saturation and past it
                n = $urandom_range(257, 264);
                while (fb.size() < n) fb.push_back(8'($urandom));
            end
            FR_NOISE: begin
                fb = {};
                n = $urandom_range(1, 30);
                repeat (n) fb.push_back(8'($urandom));
            end
            default: ;
        endcase

        for (int i = 0; i < fb.size(); i++) begin
            // noise may end early anywhere, every frame ends flagged
            byte_queue.push_back('{fb[i], (i == fb.size() - 1) ||
                                  (kind == FR_NOISE && $urandom_range(0, 19) == 0)});
        end
        added += fb.size();
    endtask

    // a mix weighted toward well-formed frames, about target bytes
    task automatic add_random_frames(int target);
        int          added;
        int          r;
        frame_kind_t kind;
        added = 0;
        while (added < target) begin
            r = $urandom_range(0, 99);
            if      (r < 55) kind = FR_GOOD;
            else if (r < 63) kind = FR_BAD_VERSION;
            else if (r < 71) kind = FR_BAD_MAGIC;
            else if (r < 79) kind = FR_BAD_CRC;
            else if (r < 86) kind = FR_SHORT;
            else if (r < 94) kind = FR_LONG;
            else             kind = FR_NOISE;
            add_frame(kind, 1'b0, added);
        end
    endtask

    // wait until the driver is empty and every result has come back
    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // byte driver, changes inputs on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_queue[0].data;
                s_tlast  <= byte_queue[0].last;
                void'(byte_queue.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, random stalls plus the requested long hold-off
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: sample handshakes on the rising edge
    always @(posedge aclk) begin
        frame_result_t want;
        in_taken = 1'b0;
        if (!aresetn) begin
            frame_clear();
            cfg_magic   = '{8'd0, 8'd0, 8'd0, 8'd0};
            cfg_version = 8'd0;
        end else begin
            // register write transaction updates the shadow
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    tfc_pkg::REG_MAGIC_0: cfg_magic[0] = pwdata[7:0];
                    tfc_pkg::REG_MAGIC_1: cfg_magic[1] = pwdata[7:0];
                    tfc_pkg::REG_MAGIC_2: cfg_magic[2] = pwdata[7:0];
                    tfc_pkg::REG_MAGIC_3: cfg_magic[3] = pwdata[7:0];
                    tfc_pkg::REG_VERSION: cfg_version  = pwdata[7:0];
                    default: ;
                endcase
            end
            // input transaction
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                n_bytes++;
                if (s_tlast) n_frames++;
                frame_model_step(s_tdata, s_tlast);
            end
            // result transaction against the oldest prediction
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: tdata %0h tuser %0h tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status",         want.status,  m_tuser[2:0]);
                    check_field("pulse_present",  want.present, m_tuser[3]);
                    check_field("frame_version",  want.version, m_tdata[7:0]);
                    check_field("frame_sequence", want.seq_num, m_tdata[15:8]);
                    check_field("channel_index",  want.channel, m_tdata[19:16]);
                    check_field("pulse_width",    want.pulse,   m_tdata[35:20]);
                    check_field("last_result",    want.last,    m_tlast);
                end
            end
        end
    end

    // run time limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("thruster_frame_checker: mismatch");
            $finish;
        end
    end

    // test sequence
    initial begin
        int added;
        added = 0;
        // reset, released on a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // phase 0: all-zero registers, no idling, a one-byte frame and a
        // good frame with extreme pulse widths
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        byte_queue.push_back('{8'hFF, 1'b1});
        add_frame(FR_GOOD, 1'b1, added);
        wait_drained();

        // phase 1: all-ones registers, sender mostly idle; each rejection
        // case once, including a frame that saturates the byte counter
        send_idle_pct = 67;
        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_frame(FR_BAD_VERSION, 1'b0, added);
        add_frame(FR_BAD_MAGIC, 1'b0, added);
        add_frame(FR_BAD_CRC, 1'b0, added);
        add_frame(FR_HUGE, 1'b0, added);
        wait_drained();

        // phase 2: random registers, receiver mostly stalled; also a write
        // to an address with no register behind it
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        apb_write(REG_UNUSED, 8'($urandom));
        add_random_frames(30);
        wait_drained();

        // phase 3: both sides idle now and then
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        add_random_frames(30);
        wait_drained();

        // phase 4: receiver holds off for a long stretch while good frames
        // keep coming, so the block backs up to its input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        @(posedge aclk);
        hold_req = ~hold_req;
        repeat (2) add_frame(FR_GOOD, 1'b0, added);
        wait_drained();

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("run covered %0d input bytes in %0d frames and %0d results",
                 n_bytes, n_frames, n_results);
        $display("under %0d register settings and five idle patterns, %0d errors",
                 n_settings, errors);
        if (errors == 0) begin
            $display("thruster_frame_checker: match");
        end else begin
            $display("thruster_frame_checker: mismatch");
        end
        $finish;
    end

endmodule
